/* rtl/core/deq_pkg.sv */
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation and status codes and the controller command bundle shared by
// the queue modules.
// ----------------------------------------------------------------------------
`default_nettype none

package deq_pkg;

  localparam int unsigned DEQ_DEPTH = 128;
  localparam int unsigned OCC_W     = 8;

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef struct packed {
    logic load;
    logic exec;
  } deq_cmd_t;

endpackage

`default_nettype wire

/* rtl/core/double_ended_queue.sv */
// ----------------------------------------------------------------------------
// Double-ended queue
// Push and pop at either end of a circular buffer of signed 32-bit words.
// ----------------------------------------------------------------------------
// A beat accepted in the idle state passes through the execute state to the
// result state, where done_o and the registered buffer read appear together.
// A new beat is taken only in the idle state; busy stays high until the result.
// Reset: pointers and count clear, the buffer contents stay undefined.
// The receiver cannot stall; done_o is high for exactly one cycle.
`default_nettype none

module double_ended_queue import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic [1:0]         operation_i,
  input  wire logic signed [31:0] push_value_i,
  output logic                    done_o,
  output logic signed [31:0]      result_value_o,
  output logic [1:0]              status_o,
  output logic [OCC_W-1:0]        occupancy_o
);

  deq_cmd_t cmd;

  deq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .operation_i    (operation_i),
    .push_value_i   (push_value_i),
    .result_value_o (result_value_o),
    .status_o       (status_o),
    .occupancy_o    (occupancy_o)
  );

endmodule

`default_nettype wire

/* rtl/core/deq_ctrl.sv */
// ----------------------------------------------------------------------------
// Double-ended queue controller
// Sequences one operation through accept, execute and result cycles and
// drives the datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_ctrl import deq_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start,
  output logic      busy,
  output logic      done_o,
  output deq_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DONE
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          done_q <= 1'b0;
          if (start) begin
            state_q <= S_EXEC;
            busy_q  <= 1'b1;
          end
        end
        S_EXEC: begin
          state_q <= S_DONE;
          done_q  <= 1'b1;
        end
        S_DONE: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
        default: begin
          state_q <= S_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b0;
        end
      endcase
    end
  end

  assign busy       = busy_q;
  assign done_o     = done_q;
  assign cmd_o.load = start && (state_q == S_IDLE);
  assign cmd_o.exec = (state_q == S_EXEC);

endmodule

`default_nettype wire

/* rtl/core/deq_datapath.sv */
// ----------------------------------------------------------------------------
// Double-ended queue datapath
// Circular buffer with front and back pointers, an entry count and the
// result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_datapath import deq_pkg::*; #(
  parameter int unsigned DEPTH = DEQ_DEPTH
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire deq_cmd_t           cmd_i,
  input  wire logic [1:0]         operation_i,
  input  wire logic signed [31:0] push_value_i,
  output logic signed [31:0]      result_value_o,
  output logic [1:0]              status_o,
  output logic [OCC_W-1:0]        occupancy_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  logic [31:0]   mem [DEPTH];
  op_e           op_q;
  logic [31:0]   val_q;
  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic [31:0]   rd_data_q;
  logic [31:0]   echo_q, echo_d;
  logic          from_mem_q, from_mem_d;
  status_e       status_q, status_d;
  logic          wr_en, rd_en;
  logic [AW-1:0] wr_addr, rd_addr;
  logic [AW-1:0] front_nx, front_pv, back_nx, back_pv;

  assign front_nx = (front_q == LAST) ? '0 : front_q + AW'(1);
  assign front_pv = (front_q == '0) ? LAST : front_q - AW'(1);
  assign back_nx  = (back_q == LAST) ? '0 : back_q + AW'(1);
  assign back_pv  = (back_q == '0) ? LAST : back_q - AW'(1);

  always_comb begin
    front_d    = front_q;
    back_d     = back_q;
    count_d    = count_q;
    echo_d     = '0;
    from_mem_d = 1'b0;
    status_d   = ST_OK;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = back_q;
    rd_addr    = front_q;
    unique case (op_q)
      OP_PUSH_BACK, OP_PUSH_FRONT: begin
        if (count_q == FULL) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          echo_d  = val_q;
          count_d = count_q + CW'(1);
          if (op_q == OP_PUSH_BACK) begin
            wr_addr = back_q;
            back_d  = back_nx;
          end else begin
            wr_addr = front_pv;
            front_d = front_pv;
          end
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en      = 1'b1;
          from_mem_d = 1'b1;
          count_d    = count_q - CW'(1);
          if (op_q == OP_POP_FRONT) begin
            rd_addr = front_q;
            front_d = front_nx;
          end else begin
            rd_addr = back_pv;
            back_d  = back_pv;
          end
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(operation_i);
      val_q <= push_value_i;
    end
    if (cmd_i.exec) begin
      echo_q   <= echo_d;
      status_q <= status_d;
      if (wr_en) begin
        mem[wr_addr] <= val_q;
      end
      if (rd_en) begin
        rd_data_q <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= '0;
      back_q     <= '0;
      count_q    <= '0;
      from_mem_q <= 1'b0;
    end else if (cmd_i.exec) begin
      front_q    <= front_d;
      back_q     <= back_d;
      count_q    <= count_d;
      from_mem_q <= from_mem_d;
    end
  end

  assign result_value_o = from_mem_q ? rd_data_q : echo_q;
  assign status_o       = status_q;
  assign occupancy_o    = OCC_W'(count_q);

endmodule

`default_nettype wire

/* rtl/core/deq_checker.sv */
// ----------------------------------------------------------------------------
// Double-ended queue checker
// Port-level properties of the queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module deq_checker import deq_pkg::*; (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               done_o,
  input wire logic signed [31:0] result_value_o,
  input wire logic [1:0]         status_o
);

  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> ##1 done_o)
    else $error("accepted beat did not give a result two cycles later");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a busy operation");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (result_value_o == 32'sd0))
    else $error("rejected operation returned a nonzero word");

endmodule

bind double_ended_queue deq_checker u_deq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .done_o         (done_o),
  .result_value_o (result_value_o),
  .status_o       (status_o)
);

`default_nettype wire
